// ===== hdl/acsc_pkg.sv =====
package acsc_pkg;

   localparam int ButtonCount    = 4;
   localparam int ButtonIdxWidth = 2;
   localparam int DayWidth       = 5;
   localparam int HourWidth      = 5;
   localparam int MinuteWidth    = 6;
   localparam int KeyWidth       = 17;
   localparam int SnoozeWidth    = 6;
   localparam int ReqDataWidth   = 24;
   localparam int RspDataWidth   = 24;

   localparam logic [KeyWidth-1:0]    NoKey         = '1;
   localparam logic [KeyWidth-1:0]    MinutesPerDay = 17'd1440;
   localparam logic [KeyWidth-1:0]    MinutesPerHr  = 17'd60;
   localparam logic [HourWidth-1:0]   HoursPerDay   = 5'd24;
   localparam logic [HourWidth-1:0]   LastHour      = 5'd23;
   localparam logic [MinuteWidth-1:0] LastMinute    = 6'd59;
   localparam logic [HourWidth-1:0]   ResetHour     = 5'd7;
   localparam logic [SnoozeWidth-1:0] ResetSnooze   = 6'd5;

   // Button roles, by index.
   localparam logic [ButtonIdxWidth-1:0] ButtonLeave  = 2'd0;
   localparam logic [ButtonIdxWidth-1:0] ButtonSnooze = 2'd1;
   localparam logic [ButtonIdxWidth-1:0] ButtonUp     = 2'd2;
   localparam logic [ButtonIdxWidth-1:0] ButtonDown   = 2'd3;

   // Status light bits.
   localparam int LedGreen = 0;
   localparam int LedRed   = 1;

   typedef enum logic [1:0] {
      FieldHour   = 2'd0,
      FieldMinute = 2'd1,
      FieldEnable = 2'd2
   } edit_field_type;

   typedef struct packed {
      logic [DayWidth-1:0]    day;
      logic [HourWidth-1:0]   hours;
      logic [MinuteWidth-1:0] minutes;
      logic [ButtonCount-1:0] buttons;
   } poll_item_type;

   typedef struct packed {
      logic                   ringing;
      logic                   buzzer_on;
      logic                   green_led;
      logic                   red_led;
      logic                   show_alarm_screen;
      logic [HourWidth-1:0]   set_hour;
      logic [MinuteWidth-1:0] set_minute;
      logic                   armed;
      logic [1:0]             editing_field;
      logic                   snooze_pending;
   } status_type;

endpackage

// ===== hdl/alarm_clock_snooze_controller.sv =====
// A poll transaction accepted into the input register is evaluated into the result register,
// where it waits until it is taken. Throughput: one transaction per cycle while results are
// taken, set by the input register feeding the result register; a waiting result lets one
// more transaction in, then stalls.
// Reset (synchronous, active high): alarm 07:00 disabled, no ring, no snooze, no match key,
// snooze length 5 minutes, both channels empty.
module alarm_clock_snooze_controller
   import acsc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Poll input: day [4:0], hours [9:5], minutes [15:10], buttons [19:16], zero fill.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   // Status result: ringing [0], buzzer_on [1], green_led [2], red_led [3],
   // show_alarm_screen [4], set_hour [9:5], set_minute [15:10], armed [16],
   // editing_field [18:17], snooze_pending [19], zero fill.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   // Snooze length register, in minutes.
   input  logic                    csr_wen,
   input  logic [SnoozeWidth-1:0]  csr_wdata
);

   // Input register stage. It refills in the same cycle it drains, and while a
   // finished result is still waiting it can hold one more transaction.
   logic          in_valid_ff, in_valid_in;
   poll_item_type in_item_ff;
   logic          out_valid_ff, out_valid_in;
   status_type    out_status_ff;
   status_type    status;
   logic          advance;
   logic          req_take;

   // The held transaction moves on whenever the result register is free or
   // is being emptied in this same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.day     <= req_tdata[4:0];
         in_item_ff.hours   <= req_tdata[9:5];
         in_item_ff.minutes <= req_tdata[15:10];
         in_item_ff.buttons <= req_tdata[19:16];
      end
      if (advance) begin
         out_status_ff <= status;
      end
   end

   // The core updates the alarm state once per transaction and reports the
   // state as it stands after that transaction.
   acsc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .item      (in_item_ff),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .status    (status)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0,
                        out_status_ff.snooze_pending,
                        out_status_ff.editing_field,
                        out_status_ff.armed,
                        out_status_ff.set_minute,
                        out_status_ff.set_hour,
                        out_status_ff.show_alarm_screen,
                        out_status_ff.red_led,
                        out_status_ff.green_led,
                        out_status_ff.buzzer_on,
                        out_status_ff.ringing};

endmodule

// ===== hdl/acsc_core.sv =====
module acsc_core
   import acsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  poll_item_type          item,
   input  logic                   csr_wen,
   input  logic [SnoozeWidth-1:0] csr_wdata,
   output status_type             status
);

   logic [SnoozeWidth-1:0] snooze_len_ff;
   logic [HourWidth-1:0]   wake_hour_ff,    wake_hour_in;
   logic [MinuteWidth-1:0] wake_minute_ff,  wake_minute_in;
   logic                   alarm_enable_ff, alarm_enable_in;
   logic                   ring_ff,         ring_in;
   logic                   snooze_ff,       snooze_in;
   logic [HourWidth-1:0]   nap_hour_ff,     nap_hour_in;
   logic [MinuteWidth-1:0] nap_minute_ff,   nap_minute_in;
   logic [KeyWidth-1:0]    last_key_ff,     last_key_in;
   logic [ButtonCount-1:0] prev_buttons_ff;
   edit_field_type         edit_field_ff,   edit_field_in;
   logic [1:0]             led_ff,          led_in;

   logic [ButtonCount-1:0]    rise;
   logic                      press;
   logic [ButtonIdxWidth-1:0] press_idx;
   logic [KeyWidth-1:0]       key;
   logic [MinuteWidth:0]      minute_sum;
   logic [MinuteWidth-1:0]    snooze_min_calc;
   logic [1:0]                hour_carry;
   logic [HourWidth:0]        hour_sum;
   logic [HourWidth-1:0]      nap_hour_calc;
   logic                      show;

   // Snooze target: minutes wrap once or twice, hours wrap once at most.
   always_comb begin
      minute_sum = {1'b0, item.minutes} + {1'b0, snooze_len_ff};
      if (minute_sum >= 7'd120) begin
         snooze_min_calc = MinuteWidth'(minute_sum - 7'd120);
         hour_carry      = 2'd2;
      end else if (minute_sum >= 7'd60) begin
         snooze_min_calc = MinuteWidth'(minute_sum - 7'd60);
         hour_carry      = 2'd1;
      end else begin
         snooze_min_calc = minute_sum[MinuteWidth-1:0];
         hour_carry      = 2'd0;
      end
      hour_sum = {1'b0, item.hours} + {4'b0, hour_carry};
      if (hour_sum >= {1'b0, HoursPerDay}) begin
         nap_hour_calc = HourWidth'(hour_sum - {1'b0, HoursPerDay});
      end else begin
         nap_hour_calc = hour_sum[HourWidth-1:0];
      end
   end

   assign key = KeyWidth'(item.day) * MinutesPerDay
              + KeyWidth'(item.hours) * MinutesPerHr
              + KeyWidth'(item.minutes);

   always_comb begin
      rise      = item.buttons & ~prev_buttons_ff;
      press     = |rise;
      press_idx = ButtonLeave;
      for (int i = 0; i < ButtonCount; i++) begin
         if (rise[i]) begin
            press_idx = ButtonIdxWidth'(i);
         end
      end

      wake_hour_in    = wake_hour_ff;
      wake_minute_in  = wake_minute_ff;
      alarm_enable_in = alarm_enable_ff;
      ring_in         = ring_ff;
      snooze_in       = snooze_ff;
      nap_hour_in     = nap_hour_ff;
      nap_minute_in   = nap_minute_ff;
      last_key_in     = last_key_ff;
      edit_field_in   = edit_field_ff;
      led_in          = led_ff;
      show            = 1'b1;

      if (ring_ff) begin
         if (press && press_idx == ButtonSnooze) begin
            nap_hour_in   = nap_hour_calc;
            nap_minute_in = snooze_min_calc;
            snooze_in     = 1'b1;
            ring_in       = 1'b0;
            last_key_in   = NoKey;
            show          = 1'b0;
         end else if (press) begin
            ring_in   = 1'b0;
            snooze_in = 1'b0;
            show      = 1'b0;
         end else begin
            led_in = 2'b10;
         end
      end else begin
         // A pending snooze replaces the alarm setting in the match check.
         if (snooze_ff) begin
            if (item.hours == nap_hour_ff && item.minutes == nap_minute_ff
                && key != last_key_ff) begin
               snooze_in   = 1'b0;
               last_key_in = key;
               ring_in     = 1'b1;
            end
         end else if (alarm_enable_ff) begin
            if (item.hours == wake_hour_ff && item.minutes == wake_minute_ff
                && key != last_key_ff) begin
               last_key_in = key;
               ring_in     = 1'b1;
            end
         end
         led_in = ring_in ? 2'b10 : {1'b0, alarm_enable_ff};

         if (!ring_in && press) begin
            unique case (press_idx)
               ButtonLeave: begin
                  edit_field_in = FieldHour;
                  show          = 1'b0;
               end
               ButtonSnooze: begin
                  unique case (edit_field_ff)
                     FieldHour:   edit_field_in = FieldMinute;
                     FieldMinute: edit_field_in = FieldEnable;
                     default:     edit_field_in = FieldHour;
                  endcase
               end
               default: begin
                  unique case (edit_field_ff)
                     FieldHour: begin
                        if (press_idx == ButtonUp) begin
                           wake_hour_in = (wake_hour_ff == LastHour) ? '0
                                          : wake_hour_ff + 5'd1;
                        end else begin
                           wake_hour_in = (wake_hour_ff == '0) ? LastHour
                                          : wake_hour_ff - 5'd1;
                        end
                     end
                     FieldMinute: begin
                        if (press_idx == ButtonUp) begin
                           wake_minute_in = (wake_minute_ff == LastMinute) ? '0
                                            : wake_minute_ff + 6'd1;
                        end else begin
                           wake_minute_in = (wake_minute_ff == '0) ? LastMinute
                                            : wake_minute_ff - 6'd1;
                        end
                     end
                     default: alarm_enable_in = ~alarm_enable_ff;
                  endcase
               end
            endcase
         end
      end

      status.ringing           = ring_in;
      status.buzzer_on         = ring_in;
      status.green_led         = led_in[LedGreen];
      status.red_led           = led_in[LedRed];
      status.show_alarm_screen = show;
      status.set_hour          = wake_hour_in;
      status.set_minute        = wake_minute_in;
      status.armed             = alarm_enable_in;
      status.editing_field     = edit_field_in;
      status.snooze_pending    = snooze_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snooze_len_ff <= ResetSnooze;
      end else if (csr_wen) begin
         snooze_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_hour_ff    <= ResetHour;
         wake_minute_ff  <= '0;
         alarm_enable_ff <= 1'b0;
         ring_ff         <= 1'b0;
         snooze_ff       <= 1'b0;
         nap_hour_ff     <= '0;
         nap_minute_ff   <= '0;
         last_key_ff     <= NoKey;
         prev_buttons_ff <= '0;
         edit_field_ff   <= FieldHour;
         led_ff          <= '0;
      end else if (enable) begin
         wake_hour_ff    <= wake_hour_in;
         wake_minute_ff  <= wake_minute_in;
         alarm_enable_ff <= alarm_enable_in;
         ring_ff         <= ring_in;
         snooze_ff       <= snooze_in;
         nap_hour_ff     <= nap_hour_in;
         nap_minute_ff   <= nap_minute_in;
         last_key_ff     <= last_key_in;
         prev_buttons_ff <= item.buttons;
         edit_field_ff   <= edit_field_in;
         led_ff          <= led_in;
      end
   end

endmodule
